// ===== rtl/core/mf3_pkg.sv =====
`default_nettype none

package mf3_pkg;

    // Fixed widths of the stream fields and registers
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int WIN_N      = 9;
    localparam int CFG_W_BITS = 12;
    localparam int CFG_H_BITS = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    // Defaults and limits
    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int RST_FRAME_WIDTH  = 640;
    localparam int RST_FRAME_HEIGHT = 480;
    localparam int MIN_DIM          = 3;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    // Input word kinds (s_tuser)
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN_N-1:0] win_t;

    // Column that enters the window on a shift
    typedef enum logic [1:0] {
        SHIFT_PIX   = 2'd0,   // upper, lower, new pixel
        SHIFT_DRAIN = 2'd1,   // upper, lower, zero
        SHIFT_ZERO  = 2'd2    // all zero
    } shift_kind_t;

    // Line buffer command for one word
    typedef struct packed {
        logic        valid;
        logic        write;
        shift_kind_t kind;
        pix_t        px;
    } lb_cmd_t;

    // Result control that travels down the pipeline
    typedef struct packed {
        logic produce;
        logic border;
        logic last;
    } res_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/median_filter_3x3_rgb_unit.sv =====
`default_nettype none

// Channel   Dir  tdata (low bit up)         tuser / tlast
// s_        in   blue, green, red (24b)     tuser: operation (0 pixel, 1 flush)
// m_        out  blue, green, red (24b)     tlast: last pixel of frame
// cfg_      in   index 0 frame_width, index 1 frame_height
//
// Takes one word per cycle while s_tready is high; each word that yields a pixel
// passes line memory read, window, column sort, candidate reduce and output registers.
// A pixel leaves one row plus one pixel of input words after it came in.
// Line memories are not cleared after reset; the window and counters are.
// An output register plus one skid word decouple m_tready; s_tready drops
// only while the skid word is occupied.

module median_filter_3x3_rgb_unit #(
    parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [mf3_pkg::PIX_W-1:0]      s_tdata,   // blue, green, red
    input  wire logic                           s_tuser,   // operation
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [mf3_pkg::PIX_W-1:0]      m_tdata,   // blue, green, red
    output logic                                m_tlast    // frame_last
);
    import mf3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic          en;
    logic [AW-1:0] rd_addr;
    lb_cmd_t       s1_cmd;
    logic [AW-1:0] s1_addr;
    res_flags_t    s1_flags;
    win_t          window;
    res_flags_t    s2_flags;
    logic          push, push_last;
    pix_t          push_data;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    pix_t out_data_reg, skid_data_reg;
    logic out_last_reg, skid_last_reg;
    logic pop, load_out, load_skid;

    // Whole pipeline moves while the skid word is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    mf3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .en       (en),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_px    (s_tdata),
        .rd_addr  (rd_addr),
        .s1_cmd   (s1_cmd),
        .s1_addr  (s1_addr),
        .s1_flags (s1_flags)
    );

    mf3_lbuf #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_lbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .rd_addr  (rd_addr),
        .cmd      (s1_cmd),
        .wr_addr  (s1_addr),
        .flags_in (s1_flags),
        .window   (window),
        .flags_out(s2_flags)
    );

    mf3_median u_median (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .window   (window),
        .flags_in (s2_flags),
        .push     (push),
        .push_data(push_data),
        .push_last(push_last)
    );

    // Output register with one skid word
    assign pop       = out_valid_reg && m_tready;
    assign load_out  = skid_valid_reg ? pop : (push && (!out_valid_reg || pop));
    assign load_skid = !skid_valid_reg && push && out_valid_reg && !pop;

    assign out_valid_next  = skid_valid_reg || push || (out_valid_reg && !pop);
    assign skid_valid_next = skid_valid_reg ? !pop : load_skid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
            out_last_reg <= skid_valid_reg ? skid_last_reg : push_last;
        end
        if (load_skid) begin
            skid_data_reg <= push_data;
            skid_last_reg <= push_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mf3_ctrl.sv =====
`default_nettype none

module mf3_ctrl #(
    parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [mf3_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire logic                             in_op,
    input  wire mf3_pkg::pix_t                    in_px,
    output logic      [$clog2(MAX_WIDTH)-1:0]     rd_addr,
    output mf3_pkg::lb_cmd_t                      s1_cmd,
    output logic      [$clog2(MAX_WIDTH)-1:0]     s1_addr,
    output mf3_pkg::res_flags_t                   s1_flags
);
    import mf3_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int ICW = $clog2(MAX_WIDTH + 1);
    localparam int IRW = $clog2(MAX_HEIGHT + 1);
    localparam int ORW = $clog2(MAX_HEIGHT);
    localparam int WCW = (ICW > CFG_W_BITS ? ICW : CFG_W_BITS) + 1;
    localparam int HCW = (IRW > CFG_H_BITS ? IRW : CFG_H_BITS) + 1;

    logic [CFG_W_BITS-1:0] frame_width_reg;
    logic [CFG_H_BITS-1:0] frame_height_reg;
    logic [ICW-1:0]        in_col_reg, in_col_next;
    logic [IRW-1:0]        in_row_reg, in_row_next;
    logic [AW-1:0]         out_col_reg, out_col_next;
    logic [ORW-1:0]        out_row_reg, out_row_next;

    logic [WCW-1:0] wide_w;
    logic [HCW-1:0] wide_h;
    logic [ICW-1:0] eff_w;
    logic [IRW-1:0] eff_h;
    logic           draining, in_col_end, out_col_end, out_row_end;
    lb_cmd_t        cmd;
    res_flags_t     flags;
    logic [AW-1:0]  addr;
    logic           accept;

    lb_cmd_t        cmd_reg;
    logic [AW-1:0]  addr_reg;
    res_flags_t     flags_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= CFG_W_BITS'(RST_FRAME_WIDTH);
            frame_height_reg <= CFG_H_BITS'(RST_FRAME_HEIGHT);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[CFG_W_BITS-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[CFG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Frame size clamped to the supported range
    assign wide_w = WCW'(frame_width_reg);
    assign wide_h = HCW'(frame_height_reg);

    always_comb begin
        if (wide_w < WCW'(MIN_DIM))        eff_w = ICW'(MIN_DIM);
        else if (wide_w > WCW'(MAX_WIDTH)) eff_w = ICW'(MAX_WIDTH);
        else                               eff_w = wide_w[ICW-1:0];
        if (wide_h < HCW'(MIN_DIM))         eff_h = IRW'(MIN_DIM);
        else if (wide_h > HCW'(MAX_HEIGHT)) eff_h = IRW'(MAX_HEIGHT);
        else                                eff_h = wide_h[IRW-1:0];
    end

    assign accept      = en && in_valid;
    assign draining    = in_row_reg >= eff_h;
    assign in_col_end  = ((ICW+1)'(in_col_reg) + (ICW+1)'(1)) >= (ICW+1)'(eff_w);
    assign out_col_end = ((ICW+1)'(out_col_reg) + (ICW+1)'(1)) >= (ICW+1)'(eff_w);
    assign out_row_end = ((IRW+1)'(out_row_reg) + (IRW+1)'(1)) >= (IRW+1)'(eff_h);

    // Per-word decisions: memory address, window shift, result flags, counters
    always_comb begin
        cmd          = '0;
        cmd.px       = in_px;
        cmd.kind     = SHIFT_PIX;
        flags        = '0;
        addr         = '0;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (draining) begin
            // every word acts as a flush once the frame is in
            cmd.valid     = 1'b1;
            flags.produce = 1'b1;
            if (in_col_reg < eff_w) begin
                cmd.kind    = SHIFT_DRAIN;
                addr        = in_col_reg[AW-1:0];
                in_col_next = in_col_reg + ICW'(1);
            end else begin
                cmd.kind    = SHIFT_ZERO;
                in_col_next = eff_w;
            end
        end else if (in_op == OP_PIXEL) begin
            cmd.valid = 1'b1;
            cmd.write = 1'b1;
            cmd.kind  = SHIFT_PIX;
            if ((ICW+1)'(in_col_reg) < (ICW+1)'(MAX_WIDTH)) addr = in_col_reg[AW-1:0];
            flags.produce = (in_row_reg >= IRW'(2)) ||
                            (in_row_reg == IRW'(1) && in_col_reg != '0);
            if (in_col_end) begin
                in_col_next = '0;
                in_row_next = in_row_reg + IRW'(1);
            end else begin
                in_col_next = in_col_reg + ICW'(1);
            end
        end

        // Output position, border test and end of frame
        if (flags.produce) begin
            flags.border = (out_row_reg == '0) || out_row_end ||
                           (out_col_reg == '0) || out_col_end;
            flags.last   = out_row_end && out_col_end;
            if (flags.last) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end else if (out_col_end) begin
                out_col_next = '0;
                out_row_next = out_row_reg + ORW'(1);
            end else begin
                out_col_next = out_col_reg + AW'(1);
            end
        end
    end

    // Position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (accept) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // Stage 1 control; payload unreset
    always_ff @(posedge aclk) begin
        if (en) begin
            cmd_reg.write <= cmd.write;
            cmd_reg.kind  <= cmd.kind;
            cmd_reg.px    <= cmd.px;
            addr_reg      <= addr;
        end
        if (!aresetn) begin
            cmd_reg.valid <= 1'b0;
            flags_reg     <= '0;
        end else if (en) begin
            cmd_reg.valid <= accept && cmd.valid;
            flags_reg     <= accept ? flags : '0;
        end
    end

    assign rd_addr  = addr;
    assign s1_cmd   = cmd_reg;
    assign s1_addr  = addr_reg;
    assign s1_flags = flags_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mf3_lbuf.sv =====
`default_nettype none

module mf3_lbuf #(
    parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  wire mf3_pkg::lb_cmd_t             cmd,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  wire mf3_pkg::res_flags_t          flags_in,
    output mf3_pkg::win_t                     window,
    output mf3_pkg::res_flags_t               flags_out
);
    import mf3_pkg::*;

    // Row two back and row one back of the input
    pix_t upper_line_mem [MAX_WIDTH];
    pix_t lower_line_mem [MAX_WIDTH];

    pix_t       up_q_reg, lo_q_reg;
    logic       fwd_hit_reg;
    pix_t       fwd_up_reg, fwd_lo_reg;
    pix_t       up_eff, lo_eff;
    logic       wr_en;
    pix_t       col_top, col_mid, col_bot;
    win_t       win_reg;
    res_flags_t flags_reg;

    assign wr_en = en && cmd.valid && cmd.write;

    // Read port, registered, held while stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            up_q_reg <= upper_line_mem[rd_addr];
            lo_q_reg <= lower_line_mem[rd_addr];
        end
    end

    // Write back: lower row moves up, new pixel becomes lower row
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_line_mem[wr_addr] <= lo_eff;
            lower_line_mem[wr_addr] <= cmd.px;
        end
    end

    // Forward a write that lands on the entry read in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fwd_up_reg <= lo_eff;
            fwd_lo_reg <= cmd.px;
        end
    end

    assign up_eff = fwd_hit_reg ? fwd_up_reg : up_q_reg;
    assign lo_eff = fwd_hit_reg ? fwd_lo_reg : lo_q_reg;

    // Column entering on the right
    always_comb begin
        case (cmd.kind)
            SHIFT_PIX: begin
                col_top = up_eff;
                col_mid = lo_eff;
                col_bot = cmd.px;
            end
            SHIFT_DRAIN: begin
                col_top = up_eff;
                col_mid = lo_eff;
                col_bot = '0;
            end
            default: begin
                col_top = '0;
                col_mid = '0;
                col_bot = '0;
            end
        endcase
    end

    // 3x3 window, row-major, shifts one column left per word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (en && cmd.valid) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]     <= win_reg[r*3+1];
                win_reg[r*3 + 1] <= win_reg[r*3+2];
            end
            win_reg[2] <= col_top;
            win_reg[5] <= col_mid;
            win_reg[8] <= col_bot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (en) begin
            flags_reg <= flags_in;
        end
    end

    assign window    = win_reg;
    assign flags_out = flags_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mf3_median.sv =====
`default_nettype none

module mf3_median (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire mf3_pkg::win_t       window,
    input  wire mf3_pkg::res_flags_t flags_in,
    output logic                     push,
    output mf3_pkg::pix_t            push_data,
    output logic                     push_last
);
    import mf3_pkg::*;

    typedef logic [CH_W-1:0] byte_t;

    typedef struct packed {
        byte_t hi;
        byte_t mid;
        byte_t lo;
    } trio_t;

    function automatic byte_t min2(input byte_t a, input byte_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic byte_t max2(input byte_t a, input byte_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic byte_t med3(input byte_t a, input byte_t b, input byte_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic trio_t sort3(input byte_t a, input byte_t b, input byte_t c);
        trio_t t;
        t.lo  = min2(min2(a, b), c);
        t.hi  = max2(max2(a, b), c);
        t.mid = med3(a, b, c);
        return t;
    endfunction

    trio_t      col_sort_reg [3][3];   // [channel][column]
    pix_t       center_s3_reg;
    res_flags_t flags_s3_reg;
    byte_t      lo_max_reg  [3];
    byte_t      mid_med_reg [3];
    byte_t      hi_min_reg  [3];
    pix_t       center_s4_reg;
    res_flags_t flags_s4_reg;
    pix_t       med_pix;

    // Stage 3: sort each window column per channel
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int c = 0; c < 3; c++) begin
                    col_sort_reg[ch][c] <= sort3(window[c][ch*CH_W +: CH_W],
                                                 window[3+c][ch*CH_W +: CH_W],
                                                 window[6+c][ch*CH_W +: CH_W]);
                end
            end
            center_s3_reg <= window[4];
        end
    end

    // Stage 4: largest low, middle mid, smallest high
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ch = 0; ch < 3; ch++) begin
                lo_max_reg[ch]  <= max2(max2(col_sort_reg[ch][0].lo, col_sort_reg[ch][1].lo),
                                        col_sort_reg[ch][2].lo);
                mid_med_reg[ch] <= med3(col_sort_reg[ch][0].mid, col_sort_reg[ch][1].mid,
                                        col_sort_reg[ch][2].mid);
                hi_min_reg[ch]  <= min2(min2(col_sort_reg[ch][0].hi, col_sort_reg[ch][1].hi),
                                        col_sort_reg[ch][2].hi);
            end
            center_s4_reg <= center_s3_reg;
        end
    end

    // Control flags alongside the data stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_s3_reg <= '0;
            flags_s4_reg <= '0;
        end else if (en) begin
            flags_s3_reg <= flags_in;
            flags_s4_reg <= flags_s3_reg;
        end
    end

    // Median of the three candidates gives the median of nine
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            med_pix[ch*CH_W +: CH_W] = med3(lo_max_reg[ch], mid_med_reg[ch], hi_min_reg[ch]);
        end
    end

    assign push      = en && flags_s4_reg.produce;
    assign push_data = flags_s4_reg.border ? center_s4_reg : med_pix;
    assign push_last = flags_s4_reg.last;

endmodule

`default_nettype wire

// ===== rtl/core/mf3_chk.sv =====
`default_nettype none

module mf3_chk (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [mf3_pkg::PIX_W-1:0] m_tdata,
    input wire logic                      m_tlast
);

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result word changed while stalled");

    // Valid only drops after the word was taken
    a_out_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result word dropped without handshake");

    // Input side only stalls when the output holds a word
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // One taken word frees the skid and reopens the input
    a_stall_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_tready && m_tready) |=> s_tready)
        else $error("input stayed stalled after output drained");

endmodule

bind median_filter_3x3_rgb_unit mf3_chk u_mf3_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

`default_nettype wire
